### hw/rtl/sld_pkg.sv
package sld_pkg;

    // byte codes used by the classifier and the decoder
    localparam logic [7:0] LEAD_PUNCT = 8'h81;
    localparam logic [7:0] LEAD_LATIN = 8'h82;

    // full-width punctuation second bytes
    localparam logic [7:0] PU_SPACE  = 8'h40;
    localparam logic [7:0] PU_PERIOD = 8'h44;
    localparam logic [7:0] PU_COLON  = 8'h46;
    localparam logic [7:0] PU_SLASH  = 8'h5E;
    localparam logic [7:0] PU_LPAREN = 8'h69;
    localparam logic [7:0] PU_RPAREN = 8'h6A;

    // full-width latin second byte ranges (first, one past last)
    localparam logic [7:0] DIGIT_LO = 8'h4F;
    localparam logic [7:0] DIGIT_HI = 8'h59;
    localparam logic [7:0] UPPER_LO = 8'h60;
    localparam logic [7:0] UPPER_HI = 8'h7A;
    localparam logic [7:0] LOWER_LO = 8'h81;
    localparam logic [7:0] LOWER_HI = 8'h9B;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // classified byte as handed from front to back
    typedef struct packed {
        logic       start;
        logic       is_zero;
        logic       lead_punct;
        logic       lead_latin;
        logic       plain_ok;
        logic [6:0] plain_ch;
        logic [6:0] punct_ch;
        logic [6:0] latin_ch;
    } item_t;

    // one result
    typedef struct packed {
        logic       accepted;
        logic       done_res;
        logic [6:0] char_out;
        logic       char_valid;
    } result_t;

endpackage

### hw/rtl/sjis_latin_string_decoder.sv
// channel | dir | tdata fields (low bit up)      | tuser      | tlast
// s_*     | in  | in_byte[7:0]                   | start_new  | -
// m_*     | out | char_valid, char_out[6:0]      | accepted   | done_res
//
// one byte per cycle while m_tready is high; a result reaches m_tvalid
// via the two-entry queue and the output register, later behind earlier bytes
// the decoder state update in the back stage sets the one-byte step
// rst_n clears queue, decoder state and output valid asynchronously
// s_tready drops only when the queue is full, so an output stall
// backs up through the queue before it reaches the input
module sjis_latin_string_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // in_byte[7:0]
    input  logic       s_tuser,  // start_new
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // char_valid, char_out[6:0]
    output logic       m_tuser,  // accepted
    output logic       m_tlast
);

    sld_pkg::item_t                in_item;
    sld_pkg::item_t                head_item;
    sld_pkg::result_t              result;
    logic                          q_full;
    logic                          q_not_empty;
    logic                          q_pop;
    logic [sld_pkg::QCNT_W-1:0]    q_level;

    // input classification
    sld_front u_front
    (
        .in_byte   (s_tdata),
        .start_new (s_tuser),
        .item      (in_item)
    );

    assign s_tready = !q_full;

    // queue between classifier and decoder
    sld_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && s_tready),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_item),
        .level     (q_level)
    );

    // stateful decoder with output register
    sld_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_not_empty),
        .item       (head_item),
        .item_take  (q_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (result)
    );

    assign m_tdata = {result.char_out, result.char_valid};
    assign m_tuser = result.accepted;
    assign m_tlast = result.done_res;

    // acceptance only comes with the end of a candidate
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("accepted without done");

    // a character is never emitted on the ending byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tlast)
        else $error("character on ending byte");

    // no character code without the valid flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[7:1] == 7'h00)
        else $error("character code without valid");

    // queue never overfills and never drains when empty
    assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= sld_pkg::QCNT_W'(sld_pkg::QUEUE_DEPTH) && (!q_pop || q_level != '0))
        else $error("queue level out of range");

endmodule

### hw/rtl/sld_front.sv
module sld_front
(
    input  logic [7:0]     in_byte,
    input  logic           start_new,
    output sld_pkg::item_t item
);

    // punctuation after the 0x81 lead, zero when no match
    function automatic logic [6:0] punct_map(input logic [7:0] b);
        logic [6:0] ch;
        begin
            ch = 7'h00;
            if (b == sld_pkg::PU_SPACE)  ch = 7'h20;
            if (b == sld_pkg::PU_PERIOD) ch = 7'h2E;
            if (b == sld_pkg::PU_COLON)  ch = 7'h3A;
            if (b == sld_pkg::PU_SLASH)  ch = 7'h2F;
            if (b == sld_pkg::PU_LPAREN) ch = 7'h28;
            if (b == sld_pkg::PU_RPAREN) ch = 7'h29;
            return ch;
        end
    endfunction

    // digits and letters after the 0x82 lead, zero when no match
    function automatic logic [6:0] latin_map(input logic [7:0] b);
        logic [7:0] up;
        logic [7:0] lo;
        logic [6:0] ch;
        begin
            up = b - 8'h1F;
            lo = b - 8'h20;
            ch = 7'h00;
            if ((b >= sld_pkg::DIGIT_LO && b < sld_pkg::DIGIT_HI) ||
                (b >= sld_pkg::UPPER_LO && b < sld_pkg::UPPER_HI))
                ch = up[6:0];
            if (b >= sld_pkg::LOWER_LO && b < sld_pkg::LOWER_HI)
                ch = lo[6:0];
            return ch;
        end
    endfunction

    // byte classification, independent of decoder state
    always_comb
    begin
        item.start      = start_new;
        item.is_zero    = (in_byte == 8'h00);
        item.lead_punct = (in_byte == sld_pkg::LEAD_PUNCT);
        item.lead_latin = (in_byte == sld_pkg::LEAD_LATIN);
        item.plain_ok   = (in_byte >= 8'h20 && in_byte < 8'h80) ||
                          in_byte == 8'h09 || in_byte == 8'h0A || in_byte == 8'h0D;
        item.plain_ch   = in_byte[6:0];
        item.punct_ch   = punct_map(in_byte);
        item.latin_ch   = latin_map(in_byte);
    end

endmodule

### hw/rtl/sld_queue.sv
module sld_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  sld_pkg::item_t             push_item,
    output logic                       full,
    input  logic                       pop,
    output logic                       not_empty,
    output sld_pkg::item_t             head,
    output logic [sld_pkg::QCNT_W-1:0] level
);

    sld_pkg::item_t                slot_reg [sld_pkg::QUEUE_DEPTH];
    logic [sld_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [sld_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [sld_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [sld_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [sld_pkg::QCNT_W-1:0]    count_reg;
    logic [sld_pkg::QCNT_W-1:0]    count_next;

    localparam logic [sld_pkg::QPTR_W-1:0] LAST_PTR = sld_pkg::QPTR_W'(sld_pkg::QUEUE_DEPTH - 1);
    localparam logic [sld_pkg::QCNT_W-1:0] FULL_CNT = sld_pkg::QCNT_W'(sld_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign level     = count_reg;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### hw/rtl/sld_back.sv
module sld_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  sld_pkg::item_t   item,
    output logic             item_take,
    output logic             res_valid,
    input  logic             res_ready,
    output sld_pkg::result_t res
);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_PUNCT  = 3'b010,
        MODE_LATIN  = 3'b100
    } mode_t;

    mode_t            mode_reg;
    mode_t            mode_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             active_reg;
    logic             active_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    sld_pkg::result_t out_reg;
    sld_pkg::result_t out_next;

    mode_t            cur_mode;
    logic [1:0]       cur_count;
    logic             cur_active;
    logic             reject;

    // take an item whenever the output register is free or being drained
    assign item_take = item_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // decode step
    always_comb
    begin
        cur_mode   = item.start ? MODE_NORMAL : mode_reg;
        cur_count  = item.start ? 2'd0 : count_reg;
        cur_active = item.start ? 1'b1 : active_reg;
        reject     = 1'b0;
        out_next   = '0;
        mode_next  = cur_mode;
        active_next = cur_active;
        if (cur_active)
        begin
            if (item.is_zero)
            begin
                out_next.done_res = 1'b1;
                out_next.accepted = (cur_count == 2'd2);
                active_next       = 1'b0;
            end
            else
            begin
                unique case (cur_mode)
                    MODE_NORMAL:
                    begin
                        if (item.lead_punct)
                            mode_next = MODE_PUNCT;
                        else if (item.lead_latin)
                            mode_next = MODE_LATIN;
                        else if (item.plain_ok)
                        begin
                            out_next.char_valid = 1'b1;
                            out_next.char_out   = item.plain_ch;
                        end
                        else
                            reject = 1'b1;
                    end
                    MODE_PUNCT:
                    begin
                        if (item.punct_ch != 7'h00)
                        begin
                            out_next.char_valid = 1'b1;
                            out_next.char_out   = item.punct_ch;
                            mode_next           = MODE_NORMAL;
                        end
                        else
                            reject = 1'b1;
                    end
                    MODE_LATIN:
                    begin
                        if (item.latin_ch != 7'h00)
                        begin
                            out_next.char_valid = 1'b1;
                            out_next.char_out   = item.latin_ch;
                            mode_next           = MODE_NORMAL;
                        end
                        else
                            reject = 1'b1;
                    end
                    default:
                        reject = 1'b1;
                endcase
            end
            if (reject)
            begin
                out_next    = '0;
                out_next.done_res = 1'b1;
                active_next = 1'b0;
            end
        end
        count_next = (out_next.char_valid && cur_count != 2'd2) ? cur_count + 2'd1 : cur_count;
        out_valid_next = item_take ? 1'b1 : (out_valid_reg && !res_ready);
    end

    // decoder state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            count_reg     <= 2'd0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_take)
            begin
                mode_reg   <= mode_next;
                count_reg  <= count_next;
                active_reg <= active_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (item_take)
            out_reg <= out_next;
    end

endmodule
